// ----- hw/rtl/word_wrap_text_placer_core_defines.svh -----
// Assertion macros for the text placer. Each expects clk and rst in scope.
`ifndef WORD_WRAP_TEXT_PLACER_CORE_DEFINES_SVH
`define WORD_WRAP_TEXT_PLACER_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define WWTP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define WWTP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/wwtp_pkg.sv -----
`default_nettype none

package wwtp_pkg;

  localparam int WWTP_MAX_WORD = 32;

  localparam int COORD_W = 11;
  localparam int SUM_W   = 12;
  localparam int CFG10_W = 10;
  localparam int COLS_W  = 6;
  localparam int CHAR_W  = 8;
  localparam int COLOR_W = 32;

  localparam logic [CHAR_W-1:0] CHAR_END   = 8'd0;
  localparam logic [CHAR_W-1:0] CHAR_TAB   = 8'd9;
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;

  localparam logic [COORD_W-1:0] COORD_MAX = 11'h7FF;

  typedef enum logic [1:0] {
    KIND_GLYPH = 2'd0,
    KIND_BLANK = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ABORT = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    REG_LEFT    = 3'd0,
    REG_TOP     = 3'd1,
    REG_COLUMNS = 3'd2,
    REG_ROWS    = 3'd3,
    REG_FG      = 3'd4,
    REG_BG      = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RIGHT,
    S_BOTTOM,
    S_BLANK,
    S_FIT,
    S_ROWS,
    S_BLANK_OUT,
    S_WORD,
    S_WRAPUP,
    S_END
  } seq_state_t;

  typedef struct packed {
    logic [CFG10_W-1:0] left;
    logic [CFG10_W-1:0] top_row;
    logic [COLS_W-1:0]  columns;
    logic [CFG10_W-1:0] rows;
  } rect_cfg_t;

  typedef struct packed {
    kind_t              kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CHAR_W-1:0]  glyph;
    logic               last;
  } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/wwtp_add_unit.sv -----
`default_nettype none

module wwtp_add_unit
  import wwtp_pkg::*;
(
  input  wire logic [SUM_W-1:0]   a,
  input  wire logic [SUM_W-1:0]   b,
  input  wire logic [COORD_W-1:0] lim,
  output logic      [SUM_W-1:0]   sum,
  output logic                    over
);

  // Shared adder with a bound check on the sum.
  assign sum  = a + b;
  assign over = sum > {1'b0, lim};

endmodule

`default_nettype wire

// ----- hw/rtl/wwtp_word_buf.sv -----
`default_nettype none

module wwtp_word_buf
  import wwtp_pkg::*;
#(
  parameter int MAX_WORD = WWTP_MAX_WORD,
  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1
) (
  input  wire logic              clk,
  input  wire logic              wr_en,
  input  wire logic [AW-1:0]     wr_addr,
  input  wire logic [CHAR_W-1:0] wr_data,
  input  wire logic [AW-1:0]     rd_addr,
  output logic      [CHAR_W-1:0] rd_data
);

  logic [CHAR_W-1:0] mem [MAX_WORD];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ----- hw/rtl/wwtp_seq.sv -----
`default_nettype none

module wwtp_seq
  import wwtp_pkg::*;
#(
  parameter int MAX_WORD = WWTP_MAX_WORD,
  localparam int LW = $clog2(MAX_WORD + 2),
  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1,
  localparam int CW = (LW > COLS_W) ? LW : COLS_W
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire rect_cfg_t         cfg,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [CHAR_W-1:0] text_byte,
  input  wire logic              slot_free,
  output logic                   emit_valid,
  output result_t                emit
);

  `include "word_wrap_text_placer_core_defines.svh"

  seq_state_t state, state_next;

  logic [COORD_W-1:0] col, col_next;
  logic [COORD_W-1:0] row, row_next;
  logic [COORD_W-1:0] right_q, right_q_next;
  logic [COORD_W-1:0] bottom_q, bottom_q_next;
  logic [COORD_W-1:0] blank_col, blank_col_next;
  logic [COORD_W-1:0] blank_row, blank_row_next;
  logic [LW-1:0]      wl, wl_next;
  logic [LW-1:0]      idx, idx_next;
  logic               prior, prior_next;
  logic               abort_flag, abort_flag_next;
  logic               owe_blank, owe_blank_next;
  logic               word_ok, word_ok_next;
  logic               end_after, end_after_next;

  logic [SUM_W-1:0]   add_a, add_b, add_sum;
  logic               add_over;
  logic               too_long;
  logic               is_last_glyph;
  logic               buf_wr_en;
  logic [CHAR_W-1:0]  rd_data;

  wwtp_add_unit u_add (
    .a    (add_a),
    .b    (add_b),
    .lim  (right_q),
    .sum  (add_sum),
    .over (add_over)
  );

  wwtp_word_buf #(.MAX_WORD(MAX_WORD)) u_buf (
    .clk     (clk),
    .wr_en   (buf_wr_en),
    .wr_addr (wl[AW-1:0]),
    .wr_data (text_byte),
    .rd_addr (idx_next[AW-1:0]),
    .rd_data (rd_data)
  );

  assign too_long = (CW'(wl) > CW'(cfg.columns)) || (wl > LW'(MAX_WORD));
  assign is_last_glyph = (idx == wl - LW'(1));
  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      col        <= '0;
      row        <= '0;
      wl         <= '0;
      idx        <= '0;
      prior      <= 1'b0;
      abort_flag <= 1'b0;
      owe_blank  <= 1'b0;
      word_ok    <= 1'b0;
      end_after  <= 1'b0;
    end else begin
      state      <= state_next;
      col        <= col_next;
      row        <= row_next;
      wl         <= wl_next;
      idx        <= idx_next;
      prior      <= prior_next;
      abort_flag <= abort_flag_next;
      owe_blank  <= owe_blank_next;
      word_ok    <= word_ok_next;
      end_after  <= end_after_next;
    end
  end

  always_ff @(posedge clk) begin
    right_q   <= right_q_next;
    bottom_q  <= bottom_q_next;
    blank_col <= blank_col_next;
    blank_row <= blank_row_next;
  end

  always_comb begin
    state_next      = state;
    col_next        = col;
    row_next        = row;
    right_q_next    = right_q;
    bottom_q_next   = bottom_q;
    blank_col_next  = blank_col;
    blank_row_next  = blank_row;
    wl_next         = wl;
    idx_next        = idx;
    prior_next      = prior;
    abort_flag_next = abort_flag;
    owe_blank_next  = owe_blank;
    word_ok_next    = word_ok;
    end_after_next  = end_after;
    buf_wr_en       = 1'b0;
    emit_valid      = 1'b0;
    emit            = '{kind: KIND_GLYPH, col: col, row: row, glyph: rd_data, last: 1'b0};
    add_a           = {1'b0, col};
    add_b           = SUM_W'(1);

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (text_byte == CHAR_END) begin
            end_after_next = 1'b1;
            state_next = (!abort_flag && wl != '0) ? S_RIGHT : S_END;
          end else if (abort_flag) begin
            state_next = S_IDLE;
          end else if (text_byte == CHAR_SPACE || text_byte == CHAR_TAB) begin
            end_after_next = 1'b0;
            if (wl != '0) begin
              state_next = S_RIGHT;
            end
          end else begin
            buf_wr_en = (wl < LW'(MAX_WORD));
            if (wl <= LW'(MAX_WORD)) begin
              wl_next = wl + LW'(1);
            end
          end
        end
      end

      S_RIGHT: begin
        add_a = SUM_W'(cfg.left);
        add_b = SUM_W'(cfg.columns);
        right_q_next = add_sum[COORD_W-1:0];
        state_next = S_BOTTOM;
      end

      S_BOTTOM: begin
        add_a = SUM_W'(cfg.top_row);
        add_b = SUM_W'(cfg.rows);
        bottom_q_next = add_sum[COORD_W-1:0];
        state_next = S_BLANK;
      end

      // Decide the separating blank; it is sent once the word's fate is known.
      S_BLANK: begin
        blank_col_next = col;
        blank_row_next = row;
        owe_blank_next = prior && (col < right_q) && (row < bottom_q);
        if (!prior) begin
          col_next = COORD_W'(cfg.left);
          row_next = COORD_W'(cfg.top_row);
        end else if ((col < right_q) && (row < bottom_q)) begin
          col_next = add_sum[COORD_W-1:0];
        end
        state_next = S_FIT;
      end

      S_FIT: begin
        add_b = SUM_W'(wl);
        if (too_long) begin
          abort_flag_next = 1'b1;
        end else if (add_over) begin
          col_next = COORD_W'(cfg.left);
          if (row != COORD_MAX) begin
            row_next = row + COORD_W'(1);
          end
        end
        state_next = S_ROWS;
      end

      S_ROWS: begin
        word_ok_next = !too_long && (row < bottom_q);
        idx_next = '0;
        if (owe_blank) begin
          state_next = S_BLANK_OUT;
        end else if (!too_long && (row < bottom_q)) begin
          state_next = S_WORD;
        end else begin
          state_next = S_WRAPUP;
        end
      end

      S_BLANK_OUT: begin
        if (slot_free) begin
          emit_valid = 1'b1;
          emit = '{kind: KIND_BLANK, col: blank_col, row: blank_row, glyph: CHAR_END,
                   last: !word_ok && !end_after};
          state_next = word_ok ? S_WORD : S_WRAPUP;
        end
      end

      S_WORD: begin
        if (slot_free) begin
          emit_valid = 1'b1;
          emit.last = is_last_glyph && !end_after;
          col_next = add_sum[COORD_W-1:0];
          idx_next = idx + LW'(1);
          if (is_last_glyph) begin
            state_next = S_WRAPUP;
          end
        end
      end

      S_WRAPUP: begin
        if (!abort_flag) begin
          prior_next = 1'b1;
        end
        wl_next = '0;
        state_next = end_after ? S_END : S_IDLE;
      end

      S_END: begin
        if (slot_free) begin
          emit_valid = 1'b1;
          emit = '{kind: (abort_flag ? KIND_ABORT : KIND_DONE), col: '0, row: '0,
                   glyph: CHAR_END, last: 1'b1};
          col_next        = COORD_W'(cfg.left);
          row_next        = COORD_W'(cfg.top_row);
          wl_next         = '0;
          prior_next      = 1'b0;
          abort_flag_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `WWTP_ASSERT_NOW(a_wl_bound, 1'b1, wl <= LW'(MAX_WORD + 1),
    "word length passed its saturation point")
  `WWTP_ASSERT_NOW(a_word_fits, state == S_WORD, word_ok && !too_long && !abort_flag,
    "replaying a word that does not fit")
  `WWTP_ASSERT_NOW(a_end_last, emit_valid && state == S_END, emit.last,
    "end-of-text result not flagged last")
  `WWTP_ASSERT_NEXT(a_end_busy, state == S_IDLE && in_valid && text_byte == CHAR_END,
    state != S_IDLE, "end of text produced no result")
  `WWTP_ASSERT_NOW(a_emit_slot, emit_valid, slot_free,
    "result issued with the output register full")

endmodule

`default_nettype wire

// ----- hw/rtl/word_wrap_text_placer_core.sv -----
// channel  | handshake                  | payload
// ---------+----------------------------+--------------------------------------------
// input    | in_valid / in_stall        | text_byte
// output   | out_valid / out_stall      | kind, cell_col, cell_row, glyph, fg_out,
//          |                            | bg_out, last
// config   | psel/penable/pwrite/pready | paddr, pwdata, prdata
//
// A word character is only buffered; the block stays ready and back-to-back
// characters are taken every cycle while they are only buffered.
// A word end (separator, or end of text with a pending word) runs bookkeeping on
// the shared adder (S_RIGHT, S_BOTTOM, S_BLANK, S_FIT), then S_ROWS, the cell writes
// (blank and glyphs) and S_WRAPUP; end of text adds the done/aborted result.
// Output stalls hold the sequencer in its emitting step; in_stall stays high
// until the sequencer is back in its idle state.
// Reset (rst, synchronous) restores the register reset values and clears the
// text state; no clearing pass is needed for the word buffer.
`default_nettype none

module word_wrap_text_placer_core
  import wwtp_pkg::*;
#(
  parameter int MAX_WORD = WWTP_MAX_WORD
) (
  input  wire logic               clk,
  input  wire logic               rst,

  // register port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,

  // text input
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [CHAR_W-1:0]  text_byte,

  // cell write output
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic      [1:0]         kind,
  output logic      [COORD_W-1:0] cell_col,
  output logic      [COORD_W-1:0] cell_row,
  output logic      [CHAR_W-1:0]  glyph,
  output logic      [COLOR_W-1:0] fg_out,
  output logic      [COLOR_W-1:0] bg_out,
  output logic                    last
);

  // Configuration registers.
  logic [CFG10_W-1:0] rect_left;
  logic [CFG10_W-1:0] rect_top;
  logic [COLS_W-1:0]  rect_columns;
  logic [CFG10_W-1:0] rect_rows;
  logic [COLOR_W-1:0] text_fg_color;
  logic [COLOR_W-1:0] text_bg_color;

  logic      cfg_wr;
  reg_idx_t  reg_idx;
  rect_cfg_t rect_cfg;

  logic    slot_free;
  logic    emit_valid;
  result_t emit;
  logic    emit_cell;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  // Register writes take effect at once; addresses past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left     <= '0;
      rect_top      <= '0;
      rect_columns  <= COLS_W'(32);
      rect_rows     <= CFG10_W'(1);
      text_fg_color <= '1;
      text_bg_color <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_LEFT:    rect_left     <= pwdata[CFG10_W-1:0];
        REG_TOP:     rect_top      <= pwdata[CFG10_W-1:0];
        REG_COLUMNS: rect_columns  <= pwdata[COLS_W-1:0];
        REG_ROWS:    rect_rows     <= pwdata[CFG10_W-1:0];
        REG_FG:      text_fg_color <= pwdata;
        REG_BG:      text_bg_color <= pwdata;
        default: begin
        end
      endcase
    end
  end

  // Readback, zero-extended.
  always_comb begin
    case (reg_idx)
      REG_LEFT:    prdata = 32'(rect_left);
      REG_TOP:     prdata = 32'(rect_top);
      REG_COLUMNS: prdata = 32'(rect_columns);
      REG_ROWS:    prdata = 32'(rect_rows);
      REG_FG:      prdata = text_fg_color;
      REG_BG:      prdata = text_bg_color;
      default:     prdata = '0;
    endcase
  end

  assign rect_cfg = '{left: rect_left, top_row: rect_top, columns: rect_columns,
                      rows: rect_rows};

  // The sequencer may hand over a result whenever the output register is
  // empty or is being drained in this cycle.
  assign slot_free = !out_valid || !out_stall;

  wwtp_seq #(.MAX_WORD(MAX_WORD)) u_seq (
    .clk        (clk),
    .rst        (rst),
    .cfg        (rect_cfg),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .text_byte  (text_byte),
    .slot_free  (slot_free),
    .emit_valid (emit_valid),
    .emit       (emit)
  );

  // Cell writes carry the colors; done and aborted items carry zeros.
  assign emit_cell = (emit.kind == KIND_GLYPH) || (emit.kind == KIND_BLANK);

  // Output register: load on a new item, drop valid once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_valid) begin
      kind     <= emit.kind;
      cell_col <= emit.col;
      cell_row <= emit.row;
      glyph    <= emit.glyph;
      fg_out   <= emit_cell ? text_fg_color : '0;
      bg_out   <= emit_cell ? text_bg_color : '0;
      last     <= emit.last;
    end
  end

endmodule

`default_nettype wire

// ----- tb/text_placement_checker.sv -----
module text_placement_checker
  import wwtp_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  input  wire logic [31:0]        prdata,
  input  wire logic               pready,
  input  wire logic               in_valid,
  input  wire logic               in_stall,
  input  wire logic [CHAR_W-1:0]  text_byte,
  input  wire logic               out_valid,
  input  wire logic               out_stall,
  input  wire logic [1:0]         kind,
  input  wire logic [COORD_W-1:0] cell_col,
  input  wire logic [COORD_W-1:0] cell_row,
  input  wire logic [CHAR_W-1:0]  glyph,
  input  wire logic [COLOR_W-1:0] fg_out,
  input  wire logic [COLOR_W-1:0] bg_out,
  input  wire logic               last,
  output int                      fail_count,
  output int                      placements_pending,
  output int                      glyphs_placed,
  output int                      blanks_placed,
  output int                      texts_done,
  output int                      texts_aborted
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_CAP = WWTP_MAX_WORD;
  localparam int BUF_AW   = $clog2(WORD_CAP);

  typedef struct {
    kind_t              kind;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [CHAR_W-1:0]  glyph;
    logic [COLOR_W-1:0] fg;
    logic [COLOR_W-1:0] bg;
    logic               last;
  } placement_t;

  // rectangle and colors as last written
  logic [CFG10_W-1:0] rc_left, rc_top, rc_rows;
  logic [COLS_W-1:0]  rc_cols;
  logic [COLOR_W-1:0] rc_fg, rc_bg;

  // text layout state
  logic [COORD_W-1:0] pen_col, pen_row;
  logic [CHAR_W-1:0]  word_buf [WORD_CAP];
  int unsigned        word_len;
  bit                 placed_any;
  bit                 text_dead;

  placement_t placements_due[$];
  int fails, glyphs, blanks, dones, aborts;

  function automatic void restart_text();
    pen_col    = COORD_W'(rc_left);
    pen_row    = COORD_W'(rc_top);
    word_len   = 0;
    placed_any = 1'b0;
    text_dead  = 1'b0;
  endfunction

  function automatic void note_failure(string msg);
    fails++;
    if (fails <= 10) $display("%s", msg);
  endfunction

  function automatic void queue_placement(kind_t k, int unsigned col, int unsigned row,
                                          logic [CHAR_W-1:0] g);
    placement_t p;
    bit is_write;
    is_write = (k == KIND_GLYPH) || (k == KIND_BLANK);
    p.kind  = k;
    p.col   = col[COORD_W-1:0];
    p.row   = row[COORD_W-1:0];
    p.glyph = g;
    p.fg    = is_write ? rc_fg : '0;
    p.bg    = is_write ? rc_bg : '0;
    p.last  = 1'b0;
    placements_due.push_back(p);
  endfunction

  function automatic logic [31:0] reg_value(logic [2:0] idx);
    case (idx)
      REG_LEFT:    return 32'(rc_left);
      REG_TOP:     return 32'(rc_top);
      REG_COLUMNS: return 32'(rc_cols);
      REG_ROWS:    return 32'(rc_rows);
      REG_FG:      return rc_fg;
      default:     return rc_bg;
    endcase
  endfunction

  function automatic void apply_reg_write(logic [2:0] idx, logic [31:0] data);
    case (idx)
      REG_LEFT:    rc_left = data[CFG10_W-1:0];
      REG_TOP:     rc_top  = data[CFG10_W-1:0];
      REG_COLUMNS: rc_cols = data[COLS_W-1:0];
      REG_ROWS:    rc_rows = data[CFG10_W-1:0];
      REG_FG:      rc_fg   = data;
      REG_BG:      rc_bg   = data;
      default: ;
    endcase
  endfunction

  // Lay out the buffered word: owed blank, wrap, then the glyphs.
  function automatic void close_word();
    int unsigned right_edge, bottom_edge, i;
    right_edge  = rc_left + rc_cols;
    bottom_edge = rc_top + rc_rows;
    if (!placed_any) begin
      pen_col = COORD_W'(rc_left);
      pen_row = COORD_W'(rc_top);
    end else if (pen_col < right_edge && pen_row < bottom_edge) begin
      queue_placement(KIND_BLANK, pen_col, pen_row, '0);
      pen_col = pen_col + 1'b1;
    end
    if (word_len > rc_cols || word_len > WORD_CAP) begin
      text_dead = 1'b1;
      word_len  = 0;
      return;
    end
    if (pen_col + word_len > right_edge) begin
      pen_col = COORD_W'(rc_left);
      if (pen_row < COORD_MAX) pen_row = pen_row + 1'b1;
    end
    if (pen_row < bottom_edge) begin
      for (i = 0; i < word_len; i++)
        queue_placement(KIND_GLYPH, pen_col + i, pen_row, word_buf[i[BUF_AW-1:0]]);
      pen_col = COORD_W'(pen_col + word_len);
    end
    placed_any = 1'b1;
    word_len   = 0;
  endfunction

  function automatic void place_char(logic [CHAR_W-1:0] c);
    int first;
    first = placements_due.size();
    if (c == CHAR_END) begin
      if (!text_dead && word_len > 0) close_word();
      queue_placement(text_dead ? KIND_ABORT : KIND_DONE, 0, 0, '0);
      restart_text();
    end else if (text_dead) begin
      // drop until end of text
    end else if (c == CHAR_SPACE || c == CHAR_TAB) begin
      if (word_len > 0) close_word();
    end else begin
      if (word_len < WORD_CAP) word_buf[word_len[BUF_AW-1:0]] = c;
      if (word_len <= WORD_CAP) word_len++;
    end
    if (placements_due.size() > first) placements_due[$].last = 1'b1;
  endfunction

  always @(posedge clk) begin : watch
    placement_t want;
    if (rst) begin
      rc_left = '0;
      rc_top  = '0;
      rc_cols = COLS_W'(WORD_CAP);
      rc_rows = CFG10_W'(1);
      rc_fg   = '1;
      rc_bg   = '0;
      restart_text();
      placements_due.delete();
    end else begin
      if (psel && penable && pready) begin
        if (pwrite)
          apply_reg_write(paddr[4:2], pwdata);
        else if (paddr[4:2] <= REG_BG && prdata !== reg_value(paddr[4:2]))
          note_failure($sformatf("register %0d read: expected %h, got %h",
                                 paddr[4:2], reg_value(paddr[4:2]), prdata));
      end
      if (in_valid && !in_stall) place_char(text_byte);
      if (out_valid && !out_stall) begin
        if (placements_due.size() == 0) begin
          note_failure($sformatf("unexpected result: kind %0d col %0d row %0d glyph %h",
                                 kind, cell_col, cell_row, glyph));
        end else begin
          want = placements_due.pop_front();
          if (kind !== want.kind || cell_col !== want.col || cell_row !== want.row ||
              glyph !== want.glyph || fg_out !== want.fg || bg_out !== want.bg ||
              last !== want.last)
            note_failure($sformatf({"result mismatch: expected kind %0d col %0d row %0d ",
                                    "glyph %h fg %h bg %h last %0b; got kind %0d col %0d ",
                                    "row %0d glyph %h fg %h bg %h last %0b"},
                                   want.kind, want.col, want.row, want.glyph, want.fg,
                                   want.bg, want.last, kind, cell_col, cell_row, glyph,
                                   fg_out, bg_out, last));
          case (want.kind)
            KIND_GLYPH: glyphs++;
            KIND_BLANK: blanks++;
            KIND_DONE:  dones++;
            default:    aborts++;
          endcase
        end
      end
    end
    fail_count         <= fails;
    placements_pending <= placements_due.size();
    glyphs_placed      <= glyphs;
    blanks_placed      <= blanks;
    texts_done         <= dones;
    texts_aborted      <= aborts;
  end

endmodule

// ----- tb/word_wrap_text_placer_core_tb.sv -----
module word_wrap_text_placer_core_tb;
  import wwtp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WORD_CAP      = WWTP_MAX_WORD;
  localparam int SETTLE_CYCLES = 64;       // worst word end: bookkeeping plus 34 writes
  localparam int HOLD_CYCLES   = 240;      // long receiver hold-off
  localparam int MAX_WORDS     = 4;        // upper bound on words per random text
  localparam logic [2:0] SPARE_SLOT = 3'd6;  // unmapped register slot
  localparam longint TIMEOUT_NS = 3_000_000;

  logic               clk;
  logic               rst;
  logic               psel, penable, pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_stall;
  logic [CHAR_W-1:0]  text_byte;
  logic               out_valid;
  logic               out_stall;
  logic [1:0]         kind;
  logic [COORD_W-1:0] cell_col, cell_row;
  logic [CHAR_W-1:0]  glyph;
  logic [COLOR_W-1:0] fg_out, bg_out;
  logic               last;

  int fail_count, placements_pending;
  int glyphs_placed, blanks_placed, texts_done, texts_aborted;

  // stimulus controls
  bit send_gaps, recv_gaps, hold_rx_req;
  int items_sent, settings_used, stim_cols;

  word_wrap_text_placer_core dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .text_byte (text_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .kind      (kind),
    .cell_col  (cell_col),
    .cell_row  (cell_row),
    .glyph     (glyph),
    .fg_out    (fg_out),
    .bg_out    (bg_out),
    .last      (last)
  );

  text_placement_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .text_byte          (text_byte),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .kind               (kind),
    .cell_col           (cell_col),
    .cell_row           (cell_row),
    .glyph              (glyph),
    .fg_out             (fg_out),
    .bg_out             (bg_out),
    .last               (last),
    .fail_count         (fail_count),
    .placements_pending (placements_pending),
    .glyphs_placed      (glyphs_placed),
    .blanks_placed      (blanks_placed),
    .texts_done         (texts_done),
    .texts_aborted      (texts_aborted)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Bound the run in case the block hangs.
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_rx_req) begin
        // keep results back long enough that the block backs up into its input
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall   <= 1'b0;
        hold_rx_req = 1'b0;
      end else if (recv_gaps && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 13)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One register transfer: setup cycle, then access until pready.
  task automatic apb_transfer(input bit wr, input logic [2:0] idx, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // Write the whole rectangle setup, then read every register back.
  task automatic set_rect(input int left, input int top_row, input int cols, input int rows,
                          input logic [31:0] fg, input logic [31:0] bg);
    apb_transfer(1'b1, REG_LEFT,    32'(left));
    apb_transfer(1'b1, REG_TOP,     32'(top_row));
    apb_transfer(1'b1, REG_COLUMNS, 32'(cols));
    apb_transfer(1'b1, REG_ROWS,    32'(rows));
    apb_transfer(1'b1, REG_FG,      fg);
    apb_transfer(1'b1, REG_BG,      bg);
    apb_transfer(1'b0, REG_LEFT,    '0);
    apb_transfer(1'b0, REG_TOP,     '0);
    apb_transfer(1'b0, REG_COLUMNS, '0);
    apb_transfer(1'b0, REG_ROWS,    '0);
    apb_transfer(1'b0, REG_FG,      '0);
    apb_transfer(1'b0, REG_BG,      '0);
    stim_cols = cols;
    settings_used++;
  endtask

  // Offer one item, optionally after an idle burst, and hold it until taken.
  task automatic put_char(input logic [CHAR_W-1:0] c);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    text_byte <= c;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic put_string(input string s);
    for (int i = 0; i < s.len(); i++) put_char(s[i]);
  endtask

  function automatic logic [CHAR_W-1:0] word_char();
    logic [CHAR_W-1:0] c;
    do c = CHAR_W'($urandom_range(1, 255)); while (c == CHAR_SPACE || c == CHAR_TAB);
    return c;
  endfunction

  task automatic put_sep();
    put_char($urandom_range(0, 1) ? CHAR_SPACE : CHAR_TAB);
  endtask

  // Drop valid, wait for every outstanding result, then let the block go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (placements_pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A well-formed text with random words; now and then an over-wide word or noise.
  task automatic send_random_text();
    int n_words, len, pick, short_cap;
    n_words   = $urandom_range(0, MAX_WORDS);
    short_cap = (stim_cols < 1) ? 1 : ((stim_cols < 6) ? stim_cols : 6);
    if ($urandom_range(0, 4) == 0) put_sep();
    for (int k = 0; k < n_words; k++) begin
      pick = $urandom_range(0, 19);
      if (pick == 0)
        len = $urandom_range(WORD_CAP + 1, WORD_CAP + 3);
      else if (pick <= 2)
        len = (stim_cols + 1 < WORD_CAP + 1) ? stim_cols + 1 : WORD_CAP + 1;
      else if (pick == 3 && stim_cols > 0)
        len = stim_cols;
      else
        len = $urandom_range(1, short_cap);
      repeat (len) put_char(word_char());
      if (k != n_words - 1 || $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 2)) put_sep();
    end
    // stray byte of any value, the end code included
    if ($urandom_range(0, 11) == 0) put_char(CHAR_W'($urandom_range(0, 255)));
    put_char(CHAR_END);
  endtask

  task automatic run_texts(input int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) send_random_text();
  endtask

  initial begin
    rst       <= 1'b1;
    psel      <= 1'b0;
    penable   <= 1'b0;
    pwrite    <= 1'b0;
    paddr     <= '0;
    pwdata    <= '0;
    in_valid  <= 1'b0;
    text_byte <= '0;
    send_gaps     = 1'b1;
    recv_gaps     = 1'b1;
    hold_rx_req   = 1'b0;
    items_sent    = 0;
    settings_used = 1;
    stim_cols     = WORD_CAP;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed texts on the reset rectangle: empty text, separators only,
    // glyph code extremes with the word closed by the end code.
    put_char(CHAR_END);
    put_string(" \t");
    put_char(CHAR_END);
    put_char(8'd1);
    put_char(8'd255);
    put_char(CHAR_TAB);
    put_char(8'd127);
    put_char(CHAR_END);
    drain();

    // Narrow two-row box: wrap onto the second row, then fall below it.
    set_rect(0, 0, 4, 2, 32'h1234_5678, 32'h9ABC_DEF0);
    put_string("ab cd ef");
    put_char(CHAR_END);
    // blank owed before an over-wide word, trailing word dropped
    put_string("a abcde x");
    put_char(CHAR_END);
    drain();

    // One-column box, each later fitting word of a text wraps; colors at opposite extremes.
    set_rect(0, 0, 1, 1023, 32'h0, 32'hFFFF_FFFF);
    run_texts(10);
    drain();

    // Far corner of the register range with a full-width single row.
    set_rect(1023, 1023, WORD_CAP, 1, $urandom, $urandom);
    run_texts(12);
    drain();

    // Zero columns and zero rows: every word aborts; also poke an unmapped slot.
    set_rect($urandom_range(0, 1023), $urandom_range(0, 1023), 0, 0, $urandom, $urandom);
    apb_transfer(1'b1, SPARE_SLOT, $urandom);
    run_texts(6);
    drain();

    // Columns wider than the word buffer: only buffer overflow aborts.
    set_rect($urandom_range(0, 1023), $urandom_range(0, 1023), 63, $urandom_range(1, 4),
             $urandom, $urandom);
    run_texts(12);
    drain();

    // Back-pressure: hold results off while a long text keeps coming.
    set_rect(5, 7, 12, 8, $urandom, $urandom);
    hold_rx_req = 1'b1;
    repeat (6) begin
      repeat ($urandom_range(2, 6)) put_char(word_char());
      put_sep();
    end
    put_char(CHAR_END);
    // pause the sender until every result is out
    drain();
    run_texts(8);
    drain();

    // Final stretch at full rate on both sides.
    send_gaps = 1'b0;
    recv_gaps = 1'b0;
    set_rect($urandom_range(0, 1023), $urandom_range(0, 1023), $urandom_range(2, 16),
             $urandom_range(0, 6), $urandom, $urandom);
    run_texts(12);
    drain();

    $display("Laid out %0d texts (%0d done, %0d aborted) from %0d bytes over %0d box setups,",
             texts_done + texts_aborted, texts_done, texts_aborted, items_sent,
             settings_used);
    $display("writing %0d glyph cells and %0d separating blanks.",
             glyphs_placed, blanks_placed);
    if (fail_count == 0 && placements_pending == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/wwtp_pkg.sv
hw/rtl/wwtp_add_unit.sv
hw/rtl/wwtp_word_buf.sv
hw/rtl/wwtp_seq.sv
hw/rtl/word_wrap_text_placer_core.sv
tb/text_placement_checker.sv
tb/word_wrap_text_placer_core_tb.sv
